// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the pattern generator.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds outside reset.
`define SLPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that holds at every edge, reset included.
`define SLPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/slpg_pkg.sv -----
// Package of the structured-light pattern generator: widths, register
// indexes, pattern codes and the quarter-wave sine table. Depends on nothing.
package slpg_pkg;

  localparam int COORD_BITS      = 12;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int SINE_QUARTER    = 1 << QUARTER_BITS;
  localparam int GAIN_BITS       = 8;
  localparam int GAINS_BITS      = 3 * GAIN_BITS;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_BITS       = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  // Full scale of a sine sample: 1.0 in unsigned Q1.15.
  localparam logic [SINE_BITS-1:0] SINE_ONE = 16'd32768;

  // Pattern codes of the mode register.
  typedef enum logic [1:0] {
    MODE_GRAY = 2'd0,
    MODE_SINE = 2'd1,
    MODE_FLAT = 2'd2
  } pattern_mode_t;

  // Quadrants of the sine phase.
  localparam logic [1:0] QUAD_RISE = 2'd0;
  localparam logic [1:0] QUAD_FALL = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_AXIS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_INDEX      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_STRIPES = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_GAINS    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINE_STEP      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINE_PHASE     = 3'd6;

  // Reset value of the packed color gains.
  localparam logic [GAINS_BITS-1:0] GAINS_RESET = 24'h191919;

  // pi/2 in Q30 and the Taylor divisors (2n)(2n+1) for n = 1..6.
  localparam logic [63:0] PIH_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  typedef logic [SINE_BITS-1:0] sine_quarter_t [SINE_QUARTER];

  // One sample of the first quadrant of max(0, sin), in Q1.15.
  function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned a);
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] s;
    longint      sum;
    z   = (PIH_Q30 * 64'(a)) >> QUARTER_BITS;
    t   = z;
    sum = longint'(z);
    for (int n = 1; n <= 6; n++) begin
      t = (((t * z) >> 30) * z) >> 30;
      t = t / 64'(TAYLOR_DIV[n-1]);
      if ((n % 2) == 1) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      return '0;
    end
    s = (64'(sum) + 64'd16384) >> 15;
    if (s > 64'(SINE_ONE)) begin
      return SINE_ONE;
    end
    return SINE_BITS'(s);
  endfunction

  // Table of the first quadrant, built at elaboration.
  function automatic sine_quarter_t build_sine_quarter();
    sine_quarter_t rom;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  localparam sine_quarter_t SINE_ROM = build_sine_quarter();

endpackage

// ----- rtl/core/structured_light_pattern_generator_top.sv -----
// Top level of the structured-light pattern generator: a five-stage pixel
// pipeline with its configuration registers. Depends on slpg_pkg and
// assert_macros.svh.
//
// Usage:
// A pixel word (pixel_column, pixel_row) enters on pix_valid/pix_stall; the
// color word (blue_out, green_out, red_out) leaves on rgb_valid/rgb_stall.
// A word moves at a rising edge where valid is high and stall is low.
// The mode register picks Gray-code stripes, a sinusoid or a flat color.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and an index beyond the list is dropped. Write
// them only while no pixel is in flight.
// A pixel accepted at an edge passes in order through the five register
// stages (select, multiply, phase add, sine lookup, gain scale) to the
// outputs. Throughput: one pixel per cycle while the receiver does not
// stall; each stage takes a new word every cycle the pipeline advances.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// pix_stall rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values (flat mode,
// gains 0x191919).
module structured_light_pattern_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  logic [slpg_pkg::COORD_BITS-1:0]     pixel_column,
  input  logic [slpg_pkg::COORD_BITS-1:0]     pixel_row,
  output logic                                rgb_valid,
  input  logic                                rgb_stall,
  output logic [slpg_pkg::GAIN_BITS-1:0]      blue_out,
  output logic [slpg_pkg::GAIN_BITS-1:0]      green_out,
  output logic [slpg_pkg::GAIN_BITS-1:0]      red_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [slpg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import slpg_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [1:0]            pattern_mode;
  logic                  pattern_axis;
  logic [3:0]            bit_index;
  logic                  invert_stripes;
  logic [GAINS_BITS-1:0] color_gains;
  logic [PHASE_BITS-1:0] sine_step;
  logic [PHASE_BITS-1:0] sine_phase;

  // Pipeline valid bits and payload.
  logic                    vld1, vld2, vld3, vld4;
  logic [COORD_BITS-1:0]   coord1;
  logic [PHASE_BITS-1:0]   prod2;
  logic                    stripe2, stripe3, stripe4;
  logic [SINE_TABLE_BITS-1:0] addr3;
  logic [SINE_BITS-1:0]    sine4;

  logic                    advance;
  logic [COORD_BITS-1:0]   coord_sel;
  logic [COORD_BITS-1:0]   gray1;
  logic [PHASE_BITS-1:0]   phase2;
  logic [1:0]              quad3;
  logic [QUARTER_BITS-1:0] r3;
  logic [QUARTER_BITS-1:0] r3_mirror;
  logic [SINE_BITS-1:0]    sine_next;
  logic [GAIN_BITS-1:0]    gain_b, gain_g, gain_r;
  logic [GAINS_BITS-1:0]   scaled_b, scaled_g, scaled_r;
  logic [GAIN_BITS-1:0]    blue_next, green_next, red_next;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode   <= MODE_FLAT;
      pattern_axis   <= 1'b0;
      bit_index      <= '0;
      invert_stripes <= 1'b0;
      color_gains    <= GAINS_RESET;
      sine_step      <= '0;
      sine_phase     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_MODE:   pattern_mode   <= cfg_data[1:0];
        REG_PATTERN_AXIS:   pattern_axis   <= cfg_data[0];
        REG_BIT_INDEX:      bit_index      <= cfg_data[3:0];
        REG_INVERT_STRIPES: invert_stripes <= cfg_data[0];
        REG_COLOR_GAINS:    color_gains    <= cfg_data[GAINS_BITS-1:0];
        REG_SINE_STEP:      sine_step      <= cfg_data;
        REG_SINE_PHASE:     sine_phase     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished word is held by the receiver.
  assign advance   = !(rgb_valid && rgb_stall);
  assign pix_stall = !advance;

  // Stage 1 logic feeds stage 2: Gray code and stripe bit.
  assign coord_sel = pattern_axis ? pixel_row : pixel_column;
  assign gray1     = coord1 ^ (coord1 >> 1);

  // Stage 2 feeds stage 3: phase offset added.
  assign phase2 = prod2 + sine_phase;

  // Stage 3 feeds stage 4: quarter-wave lookup of the sine.
  assign quad3     = addr3[SINE_TABLE_BITS-1 -: 2];
  assign r3        = addr3[QUARTER_BITS-1:0];
  assign r3_mirror = '0 - r3;

  always_comb begin
    case (quad3)
      QUAD_RISE: sine_next = SINE_ROM[r3];
      QUAD_FALL: sine_next = (r3 == '0) ? SINE_ONE : SINE_ROM[r3_mirror];
      default:   sine_next = '0;
    endcase
  end

  // Stage 4 feeds the output register: gain scaling and pattern select.
  assign gain_b   = color_gains[GAIN_BITS-1:0];
  assign gain_g   = color_gains[2*GAIN_BITS-1:GAIN_BITS];
  assign gain_r   = color_gains[3*GAIN_BITS-1:2*GAIN_BITS];
  assign scaled_b = GAINS_BITS'(gain_b) * GAINS_BITS'(sine4);
  assign scaled_g = GAINS_BITS'(gain_g) * GAINS_BITS'(sine4);
  assign scaled_r = GAINS_BITS'(gain_r) * GAINS_BITS'(sine4);

  always_comb begin
    case (pattern_mode)
      MODE_GRAY: begin
        blue_next  = stripe4 ? gain_b : '0;
        green_next = stripe4 ? gain_g : '0;
        red_next   = stripe4 ? gain_r : '0;
      end
      MODE_SINE: begin
        blue_next  = scaled_b[15 +: GAIN_BITS];
        green_next = scaled_g[15 +: GAIN_BITS];
        red_next   = scaled_r[15 +: GAIN_BITS];
      end
      MODE_FLAT: begin
        blue_next  = gain_b;
        green_next = gain_g;
        red_next   = gain_r;
      end
      default: begin
        blue_next  = '0;
        green_next = '0;
        red_next   = '0;
      end
    endcase
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (advance) begin
      vld1      <= pix_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      rgb_valid <= vld4;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (advance) begin
      coord1    <= coord_sel;
      prod2     <= PHASE_BITS'(coord1) * sine_step;
      stripe2   <= ((gray1 >> bit_index) & COORD_BITS'(1)) != '0 ? !invert_stripes
                                                                 : invert_stripes;
      addr3     <= phase2[PHASE_BITS-1 -: SINE_TABLE_BITS];
      stripe3   <= stripe2;
      sine4     <= sine_next;
      stripe4   <= stripe3;
      blue_out  <= blue_next;
      green_out <= green_next;
      red_out   <= red_next;
    end
  end

  // A held output word freezes every stage behind it.
  `SLPG_ASSERT(a_hold_freezes_pipe,
    rgb_valid && rgb_stall |=> $stable({vld1, vld2, vld3, vld4}),
    "pipeline moved while the output word was stalled")
  // An accepted pixel word always lands in the first stage.
  `SLPG_ASSERT(a_accept_enters,
    pix_valid && !pix_stall |=> vld1,
    "accepted pixel word missing from the first stage")
  // A looked-up sine sample never exceeds full scale.
  `SLPG_ASSERT(a_sine_bounded,
    vld4 |-> sine4 <= SINE_ONE,
    "sine sample above full scale")
  // Reset leaves no output word pending.
  `SLPG_ASSERT_ALWAYS(a_reset_empties,
    $past(rst) |-> !rgb_valid,
    "output word valid right after reset")

endmodule

// ----- dv/pixel_color_checker.sv -----
`timescale 1ns / 100ps
// Checker of the structured-light pattern generator: watches the pixel, color
// and register channels, predicts each color word and compares it.
// Depends on slpg_pkg for port widths, pattern codes and register indexes.
module pixel_color_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  input  logic                                pix_stall,
  input  logic [slpg_pkg::COORD_BITS-1:0]     pixel_column,
  input  logic [slpg_pkg::COORD_BITS-1:0]     pixel_row,
  input  logic                                rgb_valid,
  input  logic                                rgb_stall,
  input  logic [slpg_pkg::GAIN_BITS-1:0]      blue_out,
  input  logic [slpg_pkg::GAIN_BITS-1:0]      green_out,
  input  logic [slpg_pkg::GAIN_BITS-1:0]      red_out,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [slpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [slpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  errors,
  output int                                  outstanding
);
  import slpg_pkg::*;

  localparam int          WAVE_SIZE   = 1 << SINE_TABLE_BITS;
  localparam int          WAVE_QUART  = WAVE_SIZE / 4;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [GAIN_BITS-1:0] blue;
    logic [GAIN_BITS-1:0] green;
    logic [GAIN_BITS-1:0] red;
  } color_t;

  // Clamped sine samples in Q1.15, one per phase step of the table.
  logic [15:0] wave [WAVE_SIZE];
  color_t      expected_colors [$];

  // Shadow copy of the configuration registers.
  pattern_mode_t           cur_mode;
  logic                    row_axis;
  logic [3:0]              cur_bit;
  logic                    flip_stripes;
  logic [GAINS_BITS-1:0]   cur_gains;
  logic [PHASE_BITS-1:0]   cur_step;
  logic [PHASE_BITS-1:0]   phase_offset;

  // First-quadrant sine by a Taylor series in Q30, rounded to Q1.15.
  function automatic logic [15:0] quarter_wave(input int unsigned a);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] rounded;
    longint      acc;
    z    = (HALF_PI_Q30 * 64'(a)) >> (SINE_TABLE_BITS - 2);
    term = z;
    acc  = longint'(z);
    for (int n = 1; n <= 6; n++) begin
      term = (((term * z) >> 30) * z) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      return 16'd0;
    end
    rounded = (64'(acc) + 64'd16384) >> 15;
    return (rounded > 64'd32768) ? 16'd32768 : rounded[15:0];
  endfunction

  // Rising and falling quadrants by symmetry; the negative half stays zero.
  initial begin
    for (int k = 0; k < WAVE_SIZE; k++) begin
      if (k / WAVE_QUART == 0) begin
        wave[k] = quarter_wave(k % WAVE_QUART);
      end else if (k / WAVE_QUART == 1) begin
        wave[k] = quarter_wave(WAVE_QUART - (k % WAVE_QUART));
      end else begin
        wave[k] = 16'd0;
      end
    end
  end

  // Scales one gain byte by a sine sample, truncating.
  function automatic logic [GAIN_BITS-1:0] scale_gain(input logic [GAIN_BITS-1:0] gain,
                                                      input logic [15:0] level);
    return GAIN_BITS'((32'(gain) * 32'(level)) >> 15);
  endfunction

  // Color of one pixel under the current register settings.
  function automatic color_t predict_color(input logic [COORD_BITS-1:0] col,
                                           input logic [COORD_BITS-1:0] row);
    logic [COORD_BITS-1:0] coord;
    logic [COORD_BITS-1:0] gray;
    logic [PHASE_BITS-1:0] angle;
    logic [15:0]           level;
    logic                  lit;
    color_t                c;
    coord = row_axis ? row : col;
    c     = '0;
    case (cur_mode)
      MODE_GRAY: begin
        gray = coord ^ (coord >> 1);
        // Bits above the coordinate width read as zero.
        lit  = 1'((32'(gray) >> cur_bit) & 32'd1);
        if (lit ^ flip_stripes) begin
          c.blue  = cur_gains[7:0];
          c.green = cur_gains[15:8];
          c.red   = cur_gains[23:16];
        end
      end
      MODE_SINE: begin
        angle   = PHASE_BITS'(coord) * cur_step + phase_offset;
        level   = wave[angle[PHASE_BITS-1 -: SINE_TABLE_BITS]];
        c.blue  = scale_gain(cur_gains[7:0], level);
        c.green = scale_gain(cur_gains[15:8], level);
        c.red   = scale_gain(cur_gains[23:16], level);
      end
      MODE_FLAT: begin
        c.blue  = cur_gains[7:0];
        c.green = cur_gains[15:8];
        c.red   = cur_gains[23:16];
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  // Predict on each accepted pixel, compare on each accepted color word.
  always @(posedge clk) begin : watch
    color_t want;
    if (rst) begin
      cur_mode     <= MODE_FLAT;
      row_axis     <= 1'b0;
      cur_bit      <= '0;
      flip_stripes <= 1'b0;
      cur_gains    <= GAINS_RESET;
      cur_step     <= '0;
      phase_offset <= '0;
      expected_colors.delete();
      errors       = 0;
      outstanding  <= 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        expected_colors = {expected_colors, predict_color(pixel_column, pixel_row)};
      end
      if (rgb_valid && !rgb_stall) begin
        if (expected_colors.size() == 0) begin
          $error("color word with no pixel waiting: blue %0d green %0d red %0d",
                 blue_out, green_out, red_out);
          errors = errors + 1;
        end else begin
          want = expected_colors.pop_front();
          if (blue_out !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
            errors = errors + 1;
          end
          if (green_out !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, green_out);
            errors = errors + 1;
          end
          if (red_out !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, red_out);
            errors = errors + 1;
          end
        end
      end
      // Register writes; an index past the list is dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_MODE:   cur_mode     <= pattern_mode_t'(cfg_data[1:0]);
          REG_PATTERN_AXIS:   row_axis     <= cfg_data[0];
          REG_BIT_INDEX:      cur_bit      <= cfg_data[3:0];
          REG_INVERT_STRIPES: flip_stripes <= cfg_data[0];
          REG_COLOR_GAINS:    cur_gains    <= cfg_data[GAINS_BITS-1:0];
          REG_SINE_STEP:      cur_step     <= cfg_data;
          REG_SINE_PHASE:     phase_offset <= cfg_data;
          default: begin
          end
        endcase
      end
      outstanding <= expected_colors.size();
    end
  end

endmodule

// ----- dv/structured_light_pattern_generator_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top of the structured-light pattern generator: drives pixel and
// register traffic with random idling and gives the verdict.
// Depends on slpg_pkg, the generator top and pixel_color_checker.
module structured_light_pattern_generator_top_tb;
  import slpg_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PIPE_SETTLE     = 8;
  localparam int HOLD_CYCLES     = 40;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 100;
  localparam int SQUEEZE_PHASE   = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED  = 3'd7;
  localparam logic [1:0]                MODE_UNUSED = 2'd3;
  localparam logic [COORD_BITS-1:0]     COORD_MAX   = '1;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      pix_valid    = 1'b0;
  logic                      pix_stall;
  logic [COORD_BITS-1:0]     pixel_column = '0;
  logic [COORD_BITS-1:0]     pixel_row    = '0;
  logic                      rgb_valid;
  logic                      rgb_stall    = 1'b0;
  logic [GAIN_BITS-1:0]      blue_out;
  logic [GAIN_BITS-1:0]      green_out;
  logic [GAIN_BITS-1:0]      red_out;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  logic calm    = 1'b0;
  logic squeeze = 1'b0;
  int   errors;
  int   outstanding;
  int   cycles  = 0;

  structured_light_pattern_generator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .rgb_valid    (rgb_valid),
    .rgb_stall    (rgb_stall),
    .blue_out     (blue_out),
    .green_out    (green_out),
    .red_out      (red_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pixel_color_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .rgb_valid    (rgb_valid),
    .rgb_stall    (rgb_stall),
    .blue_out     (blue_out),
    .green_out    (green_out),
    .red_out      (red_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("structured_light_pattern_generator_top_tb: errors");
      $finish;
    end
  end

  // Color receiver: short random stalls, and one long hold-off that backs up
  // the pipeline while pixels keep coming.
  initial begin : receiver
    logic held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze && !held) begin
        rgb_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rgb_stall <= 1'b0;
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rgb_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rgb_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Offers one pixel word, maybe after a short gap, and waits until taken.
  task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pix_valid    <= 1'b1;
    pixel_column <= col;
    pixel_row    <= row;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for back-to-back writes.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register; unused upper data bits carry random junk.
  task automatic program_pattern(input logic [1:0]            mode_code,
                                 input logic                  axis,
                                 input logic [3:0]            bit_sel,
                                 input logic                  invert,
                                 input logic [GAINS_BITS-1:0] gains,
                                 input logic [PHASE_BITS-1:0] step,
                                 input logic [PHASE_BITS-1:0] offset);
    write_reg(REG_PATTERN_MODE, ($urandom & ~32'h3) | 32'(mode_code));
    write_reg(REG_PATTERN_AXIS, ($urandom & ~32'h1) | 32'(axis));
    write_reg(REG_BIT_INDEX, ($urandom & ~32'hF) | 32'(bit_sel));
    write_reg(REG_INVERT_STRIPES, ($urandom & ~32'h1) | 32'(invert));
    write_reg(REG_COLOR_GAINS, ($urandom & ~32'hFFFFFF) | 32'(gains));
    write_reg(REG_SINE_STEP, step);
    write_reg(REG_SINE_PHASE, offset);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering pixels and waits until every color word is back.
  task automatic drain_pipeline();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0]            mode_pick;
    logic [GAINS_BITS-1:0] gains_pick;
    logic [PHASE_BITS-1:0] step_pick;
    logic [COORD_BITS-1:0] next_col;
    logic [COORD_BITS-1:0] next_row;
    next_col = '0;
    next_row = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: flat color with the default gains.
    send_pixel('0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_pipeline();

    // A write past the register list must change nothing.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_pixel(12'h5A5, 12'hA5A);
    drain_pipeline();

    // Gray-code stripes along columns, lowest bit, full gains.
    program_pattern(MODE_GRAY, 1'b0, 4'd0, 1'b0, 24'hFFFFFF, '0, '0);
    send_pixel(12'd0, 12'd7);
    send_pixel(12'd1, 12'd7);
    send_pixel(12'd2, 12'd7);
    send_pixel(12'd3, 12'd7);
    send_pixel(COORD_MAX, 12'd7);
    drain_pipeline();

    // Along rows, top bit, inverted.
    program_pattern(MODE_GRAY, 1'b1, 4'd11, 1'b1, 24'h123456, '0, '0);
    send_pixel(COORD_MAX, 12'd0);
    send_pixel(12'd0, 12'd2048);
    send_pixel(12'd0, COORD_MAX);
    drain_pipeline();

    // A bit above the coordinate width reads zero, inverted or not.
    program_pattern(MODE_GRAY, 1'b0, 4'd15, 1'b1, 24'hFFFFFF, '0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_pipeline();
    program_pattern(MODE_GRAY, 1'b0, 4'd15, 1'b0, 24'hFFFFFF, '0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_pipeline();

    // Sine crest and the clamped negative half.
    program_pattern(MODE_SINE, 1'b0, 4'd0, 1'b0, 24'hFFFFFF, '0, 32'h4000_0000);
    send_pixel(12'd100, 12'd0);
    drain_pipeline();
    program_pattern(MODE_SINE, 1'b0, 4'd0, 1'b0, 24'hFFFFFF, '0, 32'hC000_0000);
    send_pixel(12'd100, 12'd0);
    drain_pipeline();

    // Largest step and offset: the phase wraps.
    program_pattern(MODE_SINE, 1'b0, 4'd0, 1'b1, 24'hFFFFFF, '1, '1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(COORD_MAX, 12'd0);
    drain_pipeline();

    // The unused mode code gives black.
    program_pattern(MODE_UNUSED, 1'b0, 4'd0, 1'b0, 24'hFFFFFF, '0, '0);
    send_pixel(12'd33, 12'd44);
    drain_pipeline();

    // Random settings, each with a mix of raster runs and scattered pixels.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    mode_pick = MODE_GRAY;
        3, 4, 5, 6: mode_pick = MODE_SINE;
        7, 8:       mode_pick = MODE_FLAT;
        default:    mode_pick = MODE_UNUSED;
      endcase
      case ($urandom_range(0, 3))
        0:       gains_pick = '1;
        1:       gains_pick = '0;
        default: gains_pick = GAINS_BITS'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       step_pick = '0;
        1:       step_pick = '1;
        2:       step_pick = $urandom;
        default: step_pick = $urandom_range(0, 32'h0040_0000);
      endcase
      if (p == 0) begin
        mode_pick  = MODE_SINE;
        gains_pick = '1;
      end else if (p == 1) begin
        gains_pick = '0;
        step_pick  = '0;
      end
      calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
      if (p == SQUEEZE_PHASE) begin
        squeeze <= 1'b1;
      end
      program_pattern(mode_pick, 1'($urandom), 4'($urandom), 1'($urandom),
                      gains_pick, step_pick, $urandom);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          next_col = COORD_BITS'($urandom);
          next_row = COORD_BITS'($urandom);
        end else begin
          // Raster order: the column runs, the row steps on its wrap.
          {next_row, next_col} = {next_row, next_col} + 1'b1;
        end
        send_pixel(next_col, next_row);
      end
      drain_pipeline();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("structured_light_pattern_generator_top_tb: clean");
    end else begin
      $display("structured_light_pattern_generator_top_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/slpg_pkg.sv
rtl/core/structured_light_pattern_generator_top.sv
dv/pixel_color_checker.sv
dv/structured_light_pattern_generator_top_tb.sv
